>>> sv/mbp_pkg.sv
package mbp_pkg;

  // Width of the saturating start-code emulation counter.
  localparam int COUNT_W   = 16;
  // Width of the emulation count carried in each output word.
  localparam int EMU_W     = 16;
  // Most bytes that one input word can complete.
  localparam int BYTES_MAX = 4;
  // Held bits (up to 7) followed by a code of up to 32 bits, byte padded.
  localparam int ACC_W     = 40;
  // Widths of the packed channel payloads.
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [1:0] {
    CMD_WRITE       = 2'd0,
    CMD_ALIGN_ONES  = 2'd1,
    CMD_FLUSH_ZEROS = 2'd2,
    CMD_TRAILING    = 2'd3
  } cmd_t;

  // Everything the packer carries from one input word to the next.
  typedef struct packed {
    logic [7:0]         held_byte;
    logic [2:0]         held_bits;
    logic [7:0]         prev_byte;
    logic [7:0]         prev2_byte;
    logic [1:0]         hist_len;
    logic               matched;
    logic [COUNT_W-1:0] emu_cnt;
  } pack_state_t;

  // The group of bytes completed by one input word.
  typedef struct packed {
    logic [2:0]                      n_bytes;
    logic [BYTES_MAX-1:0][7:0]       bytes;
    logic [BYTES_MAX-1:0][EMU_W-1:0] counts;
    logic [2:0]                      pending;
  } batch_t;

  // Low EMU_W bits of the counter, zero extended when the counter is narrower.
  function automatic logic [EMU_W-1:0] emu_field(input logic [COUNT_W-1:0] c);
    logic [EMU_W+COUNT_W-1:0] w;
    w = {{EMU_W{1'b0}}, c};
    return w[EMU_W-1:0];
  endfunction

endpackage

>>> sv/msb_first_bit_packer_unit.sv
// Pipeline: an accepted word waits in the input register and is packed on its way
// into the result register, from which its bytes are offered in order, one per
// cycle while out_tready is high.
// Throughput: one input word per cycle when it completes at most one byte and
// out_tready is high; a word of more bytes (up to four) holds the result register.
// Reset: synchronous, active low; clears the held bits, byte history and counter.
module msb_first_bit_packer_unit
  import mbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [31:0] code_value, [37:32] bit_count, [39:38] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] command
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] out_byte, [23:8] emulation_count, [26:24] pending_bits, [31:27] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // last_of_run: the final byte completed by an input word
  output logic                  out_tlast
);

  // Input register: holds one accepted word until the packer can take it.
  logic        item_valid_r;
  logic [1:0]  cmd_r;
  logic [31:0] val_r;
  logic [5:0]  cnt_r;

  // Persistent packing state.
  pack_state_t state_r;
  pack_state_t state_nxt;

  // Result register: the bytes completed by the last packed word, drained one
  // per cycle through idx_r while out_tready is high.
  logic        batch_valid_r;
  batch_t      batch_r;
  batch_t      batch_nxt;
  logic [1:0]  idx_r;

  logic        out_last;
  logic        batch_free;
  logic        advance;

  assign out_last   = ({1'b0, idx_r} + 3'd1) == batch_r.n_bytes;
  // The result register can take a new group once its last byte is leaving.
  assign batch_free = !batch_valid_r || (out_tready && out_last);
  assign advance    = item_valid_r && batch_free;
  // The input register refills in the same cycle that its word moves on.
  assign in_tready  = !item_valid_r || batch_free;

  mbp_pack_core u_core (
    .command    (cmd_r),
    .code_value (val_r),
    .bit_count  (cnt_r),
    .state_cur  (state_r),
    .state_nxt  (state_nxt),
    .batch      (batch_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tready) begin
      item_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r <= in_tuser;
      val_r <= in_tdata[31:0];
      cnt_r <= in_tdata[37:32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // A word that completes no byte still updates the state but leaves no group.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batch_valid_r <= 1'b0;
      idx_r         <= 2'd0;
    end else if (batch_free) begin
      batch_valid_r <= advance && (batch_nxt.n_bytes != 3'd0);
      idx_r         <= 2'd0;
    end else if (out_tready) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      batch_r <= batch_nxt;
    end
  end

  assign out_tvalid = batch_valid_r;
  assign out_tlast  = out_last;
  assign out_tdata  = {5'd0, batch_r.pending, batch_r.counts[idx_r], batch_r.bytes[idx_r]};

endmodule

>>> sv/mbp_pack_core.sv
module mbp_pack_core
  import mbp_pkg::*;
(
  input  logic [1:0]  command,
  input  logic [31:0] code_value,
  input  logic [5:0]  bit_count,
  input  pack_state_t state_cur,
  output pack_state_t state_nxt,
  output batch_t      batch
);

  always_comb begin
    logic [5:0]       n;
    logic [31:0]      v;
    logic             flush;
    logic [32:0]      mask;
    logic [5:0]       total;
    logic [2:0]       nb;
    logic [2:0]       r;
    logic [6:0]       sh;
    logic [ACC_W-1:0] acc;
    logic [5:0]       base;
    logic             flush_emit;
    logic [2:0]       n_out;
    logic [7:0]       b;
    logic             hit;
    pack_state_t      s;

    unique case (command)
      CMD_WRITE: begin
        n     = (bit_count > 6'd32) ? 6'd32 : bit_count;
        v     = code_value;
        flush = 1'b0;
      end
      CMD_ALIGN_ONES: begin
        n     = {3'b000, 3'd0 - state_cur.held_bits};
        v     = '1;
        flush = 1'b0;
      end
      CMD_FLUSH_ZEROS: begin
        n     = 6'd0;
        v     = '0;
        flush = 1'b1;
      end
      default: begin
        n     = 6'd1;
        v     = 32'd1;
        flush = 1'b1;
      end
    endcase

    mask = (33'd1 << n) - 33'd1;
    v    = v & mask[31:0];

    // Held bits sit at the top of the word, the new code right behind them.
    total = {3'b000, state_cur.held_bits} + n;
    nb    = total[5:3];
    r     = total[2:0];
    sh    = 7'(ACC_W) - {4'b0000, state_cur.held_bits} - {1'b0, n};
    acc   = {state_cur.held_byte, 32'd0} | ({8'd0, v} << sh);
    base  = 6'(ACC_W - 1) - {nb, 3'b000};

    // A zero flush of a partial byte is just the next byte slot of the word.
    flush_emit = flush && (r != 3'd0);
    n_out      = nb + {2'b00, flush_emit};

    s = state_cur;
    s.held_byte = flush ? 8'd0 : acc[base -: 8];
    s.held_bits = flush ? 3'd0 : r;

    batch.bytes  = '0;
    batch.counts = '0;
    for (int k = 0; k < BYTES_MAX; k++) begin
      b   = acc[ACC_W-1-8*k -: 8];
      hit = (s.hist_len == 2'd2) && !s.matched && (s.prev2_byte == 8'd0) &&
            (s.prev_byte == 8'd0) && (b <= 8'd3);
      if (3'(k) < n_out) begin
        if (hit) begin
          if (s.emu_cnt != '1) begin
            s.emu_cnt = s.emu_cnt + COUNT_W'(1);
          end
          s.matched = 1'b1;
        end else begin
          s.matched = 1'b0;
        end
        s.prev2_byte = s.prev_byte;
        s.prev_byte  = b;
        if (s.hist_len != 2'd2) begin
          s.hist_len = s.hist_len + 2'd1;
        end
        batch.bytes[k]  = b;
        batch.counts[k] = emu_field(s.emu_cnt);
      end
    end

    batch.n_bytes = n_out;
    batch.pending = s.held_bits;
    state_nxt     = s;
  end

endmodule

>>> verif/tb_msb_first_bit_packer_unit.sv
`timescale 1ns / 1ps

module tb_msb_first_bit_packer_unit
  import mbp_pkg::*;
();

  localparam int RANDOM_WORDS   = 250;
  localparam int QUIET_LIMIT    = 2000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int ZERO_RUN_WORDS = 20;
  localparam int DRAIN_CYCLES   = 16;
  localparam int MAX_REPORTS    = 10;

  // One byte that the packer should deliver, with its sideband fields.
  typedef struct {
    bit [7:0]       out_byte;
    bit             last;
    bit [EMU_W-1:0] emu_count;
    bit [2:0]       pending;
  } byte_expect_t;

  // Mirrors the bit packer and the start-code emulation counter, and holds
  // the bytes still owed by the block in stream order.
  class packed_byte_checker;
    bit [7:0]         held_byte;
    bit [2:0]         held_bits;
    bit [7:0]         prev_byte;
    bit [7:0]         prev2_byte;
    bit [1:0]         hist_len;
    bit               matched;
    bit [COUNT_W-1:0] emu_cnt;
    byte_expect_t     expected_bytes[$];
    bit [7:0]         new_bytes[$];
    bit [EMU_W-1:0]   new_counts[$];
    int               mismatches;

    function int pending_count();
      return expected_bytes.size();
    endfunction

    // A window of two zero bytes and a small byte counts once; the window
    // after a hit starts at the byte that completed the hit.
    function void emit(bit [7:0] b);
      if (hist_len >= 2 && !matched && prev2_byte == 8'd0 && prev_byte == 8'd0 &&
          b <= 8'd3) begin
        if (emu_cnt != '1) emu_cnt++;
        matched = 1'b1;
      end else begin
        matched = 1'b0;
      end
      prev2_byte = prev_byte;
      prev_byte = b;
      if (hist_len < 2) hist_len++;
      new_bytes = {new_bytes, b};
      new_counts = {new_counts, emu_cnt[EMU_W-1:0]};
    endfunction

    function void put_code(bit [31:0] code, int unsigned n);
      bit [63:0]   acc;
      bit [63:0]   shifted;
      int unsigned hb;
      int unsigned total;
      int unsigned r;
      if (n > 32) n = 32;
      if (n < 32) code = code & ((32'd1 << n) - 32'd1);
      hb = held_bits;
      acc = {56'd0, held_byte} >> (8 - hb);
      acc = (acc << n) | {32'd0, code};
      total = hb + n;
      r = total % 8;
      for (int k = 0; k < total / 8; k++) begin
        shifted = acc >> (total - 8 * (k + 1));
        emit(shifted[7:0]);
      end
      shifted = acc << (8 - r);
      held_byte = shifted[7:0];
      held_bits = 3'(r);
    endfunction

    function void flush_zeros();
      if (held_bits != 3'd0) begin
        emit(held_byte);
        held_byte = 8'd0;
        held_bits = 3'd0;
      end
    endfunction

    // Applies one accepted input word and queues the bytes it completes.
    function void absorb_word(cmd_t cmd, bit [31:0] code, bit [5:0] count);
      int unsigned n;
      byte_expect_t e;
      new_bytes.delete();
      new_counts.delete();
      case (cmd)
        CMD_WRITE: put_code(code, count);
        CMD_ALIGN_ONES: begin
          n = (8 - held_bits) & 7;
          put_code((32'd1 << n) - 32'd1, n);
        end
        CMD_FLUSH_ZEROS: flush_zeros();
        CMD_TRAILING: begin
          put_code(32'd1, 1);
          flush_zeros();
        end
      endcase
      foreach (new_bytes[k]) begin
        e.out_byte = new_bytes[k];
        e.last = (k == new_bytes.size() - 1);
        e.emu_count = new_counts[k];
        e.pending = held_bits;
        expected_bytes = {expected_bytes, e};
      end
    endfunction

    function void compare_field(string name, bit [31:0] want, bit [31:0] got);
      if (want != got) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%s mismatch: expected %0h, got %0h", name, want, got);
      end
    endfunction

    function void check_byte(bit [OUT_DATA_W-1:0] data, bit last);
      byte_expect_t e;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("output word %h with tlast %0b arrived with nothing expected", data, last);
        return;
      end
      e = expected_bytes.pop_front();
      compare_field("out_byte", e.out_byte, data[7:0]);
      compare_field("emulation_count", e.emu_count, data[23:8]);
      compare_field("pending_bits", e.pending, data[26:24]);
      compare_field("tdata padding", 32'd0, data[31:27]);
      compare_field("tlast", e.last, last);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  packed_byte_checker checker_q = new();
  bit full_rate   = 1'b0;
  bit rx_hold_req = 1'b0;
  int tx_burst    = 0;
  int rx_burst    = 0;

  msb_first_bit_packer_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one, and occasional bursts with none.
  function automatic int pick_gap(inout int burst_left);
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(cmd_t cmd, bit [31:0] code, bit [5:0] count);
    int gap;
    gap = full_rate ? 0 : pick_gap(tx_burst);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = {2'b00, count, code};
    in_tuser = cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    checker_q.absorb_word(cmd, code, count);
  endtask

  task automatic pause_until_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (checker_q.pending_count() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        out_tready = 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        rx_hold_req = 1'b0;
      end
      stall = full_rate ? 0 : pick_gap(rx_burst);
      if (stall == 0) begin
        out_tready = 1'b1;
      end else begin
        out_tready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) checker_q.check_byte(out_tdata, out_tlast);
  end

  // Watchdog: the run is stuck once neither channel has moved a word for a while.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int        r;
    cmd_t      cmd;
    bit [31:0] code;
    bit [5:0]  count;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed words: empty writes and flushes, full and oversized widths,
    // stray value bits, every command with and without held bits, and
    // start-code emulation hits and near misses.
    send_word(CMD_WRITE, 32'hFFFF_FFFF, 6'd0);
    send_word(CMD_ALIGN_ONES, $urandom, 6'($urandom));
    send_word(CMD_FLUSH_ZEROS, $urandom, 6'($urandom));
    send_word(CMD_WRITE, 32'hFFFF_FFFF, 6'd32);
    send_word(CMD_WRITE, 32'h0000_0000, 6'd32);
    send_word(CMD_WRITE, 32'h0000_0001, 6'd8);
    send_word(CMD_WRITE, 32'hFFFF_FFFF, 6'd3);
    send_word(CMD_ALIGN_ONES, $urandom, 6'($urandom));
    send_word(CMD_WRITE, 32'hFFFF_FFF5, 6'd3);
    send_word(CMD_FLUSH_ZEROS, $urandom, 6'($urandom));
    send_word(CMD_TRAILING, $urandom, 6'($urandom));
    send_word(CMD_WRITE, 32'h0000_007F, 6'd7);
    send_word(CMD_TRAILING, $urandom, 6'($urandom));
    send_word(CMD_WRITE, 32'h0000_0001, 6'd1);
    send_word(CMD_TRAILING, $urandom, 6'($urandom));
    send_word(CMD_WRITE, 32'hDEAD_BEEF, 6'd63);
    send_word(CMD_WRITE, 32'hCAFE_F00D, 6'd33);
    send_word(CMD_WRITE, 32'h0000_0003, 6'd5);
    send_word(CMD_WRITE, 32'hABCD_E123, 6'd32);
    send_word(CMD_WRITE, 32'h0000_0000, 6'd24);
    send_word(CMD_WRITE, 32'h0000_0003, 6'd32);
    send_word(CMD_FLUSH_ZEROS, $urandom, 6'($urandom));
    send_word(CMD_WRITE, 32'h0000_0300, 6'd24);
    send_word(CMD_WRITE, 32'h0000_0004, 6'd24);
    send_word(CMD_WRITE, 32'h0000_0002, 6'd40);

    // Random words, biased towards zeros and small values so that emulation
    // windows turn up often; the sender drains once half way through.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70) cmd = CMD_WRITE;
      else if (r < 80) cmd = CMD_ALIGN_ONES;
      else if (r < 90) cmd = CMD_FLUSH_ZEROS;
      else cmd = CMD_TRAILING;
      r = $urandom_range(0, 99);
      if (r < 10) count = 6'($urandom_range(33, 63));
      else if (r < 40) count = 6'(8 * $urandom_range(1, 4));
      else count = 6'($urandom_range(0, 32));
      code = ($urandom_range(0, 99) < 35) ? 32'($urandom_range(0, 3)) : $urandom;
      send_word(cmd, code, count);
      if (i == RANDOM_WORDS / 2) pause_until_drained();
    end

    // Long receiver hold-off while wide writes keep coming, so the block fills
    // and stalls its input.
    pause_until_drained();
    rx_hold_req = 1'b1;
    repeat (40) send_word(CMD_WRITE, $urandom, 6'd32);
    pause_until_drained();

    // A run of zero writes back to back at full rate, dense with emulation windows.
    send_word(CMD_FLUSH_ZEROS, $urandom, 6'($urandom));
    pause_until_drained();
    full_rate = 1'b1;
    repeat (ZERO_RUN_WORDS) send_word(CMD_WRITE, 32'h0000_0000, 6'd32);
    full_rate = 1'b0;
    repeat (20) begin
      send_word(CMD_WRITE, 32'($urandom_range(0, 1)), 6'(8 * $urandom_range(1, 4)));
    end

    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (checker_q.mismatches == 0 && checker_q.pending_count() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
